@@ src/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, quiet in reset
`define HLT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock edge, quiet in reset
`define HLT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/hlt_pkg.sv @@
package hlt_pkg;

    // width of the bracket nesting counter
    localparam int DEPTH_BITS = 8;

    typedef logic [DEPTH_BITS-1:0] depth_t;

    localparam depth_t DEPTH_MAX = {DEPTH_BITS{1'b1}};

    // byte codes that steer the tokenizer
    localparam logic [7:0] CHAR_SEMI    = 8'h3B;
    localparam logic [7:0] CHAR_LPAREN  = 8'h28;
    localparam logic [7:0] CHAR_RPAREN  = 8'h29;
    localparam logic [7:0] CHAR_QUOTE   = 8'h22;
    localparam logic [7:0] CHAR_BSLASH  = 8'h5C;
    localparam logic [7:0] CHAR_LOWER_N = 8'h6E;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_NONE    = 8'h00;

    localparam logic ACTION_CHAR = 1'b0;
    localparam logic ACTION_EOL  = 1'b1;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_END    = 2'd1,
        KIND_DONE   = 2'd2,
        KIND_MORE   = 2'd3
    } kind_t;

    typedef struct packed {
        logic       action;
        logic [7:0] char_code;
        logic       trimmed;
        logic       line_is_last;
    } item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_char;
        logic       last;
    } result_t;

    // up to two results of one item, in order
    typedef struct packed {
        result_t    r0;
        result_t    r1;
        logic [1:0] cnt;
    } res_pair_t;

    // append one result; the newest one carries the last mark
    function automatic res_pair_t push_result(res_pair_t p, kind_t k, logic [7:0] ch);
        res_pair_t q;
        q = p;
        if (p.cnt == 2'd0)
        begin
            q.r0.kind     = k;
            q.r0.out_char = ch;
            q.r0.last     = 1'b1;
            q.cnt         = 2'd1;
        end
        else
        begin
            q.r0.last     = 1'b0;
            q.r1.kind     = k;
            q.r1.out_char = ch;
            q.r1.last     = 1'b1;
            q.cnt         = 2'd2;
        end
        return q;
    endfunction

endpackage

@@ src/hlt_char_if.sv @@
interface hlt_char_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] char_code;
    logic       trimmed;
    logic       line_is_last;

    modport source (output valid, action, char_code, trimmed, line_is_last, input ready);
    modport sink   (input valid, action, char_code, trimmed, line_is_last, output ready);
endinterface

@@ src/hlt_token_if.sv @@
interface hlt_token_if;
    logic          valid;
    logic          ready;
    hlt_pkg::kind_t kind;
    logic [7:0]    out_char;
    logic          last;

    modport source (output valid, kind, out_char, last, input ready);
    modport sink   (input valid, kind, out_char, last, output ready);
endinterface

@@ src/hlt_step.sv @@
module hlt_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  hlt_pkg::item_t     item,
    output hlt_pkg::res_pair_t res
);

    logic           in_quote_reg,       in_quote_next;
    logic           escape_pending_reg, escape_pending_next;
    hlt_pkg::depth_t paren_depth_reg,   paren_depth_next;
    logic           token_nonempty_reg, token_nonempty_next;
    logic           comment_skip_reg,   comment_skip_next;

    hlt_pkg::depth_t depth_up;
    logic           depth_zero;
    logic           depth_one;
    logic [7:0]     c;

    assign c          = item.char_code;
    assign depth_zero = (paren_depth_reg == '0);
    assign depth_one  = (paren_depth_reg == hlt_pkg::depth_t'(1));
    assign depth_up   = (paren_depth_reg != hlt_pkg::DEPTH_MAX)
                      ? paren_depth_reg + hlt_pkg::depth_t'(1) : paren_depth_reg;

    always_comb
    begin
        in_quote_next       = in_quote_reg;
        escape_pending_next = escape_pending_reg;
        paren_depth_next    = paren_depth_reg;
        token_nonempty_next = token_nonempty_reg;
        comment_skip_next   = comment_skip_reg;
        res                 = '0;

        if (item.action == hlt_pkg::ACTION_CHAR)
        begin
            if (!item.trimmed && !comment_skip_reg)
            begin
                if (in_quote_reg && !escape_pending_reg && c == hlt_pkg::CHAR_BSLASH)
                begin
                    escape_pending_next = 1'b1;
                end
                else if (!in_quote_reg && !(!escape_pending_reg && c == hlt_pkg::CHAR_QUOTE)
                         && c == hlt_pkg::CHAR_SEMI
                         && !(depth_zero && (c == hlt_pkg::CHAR_SPACE
                                             || c == hlt_pkg::CHAR_TAB)))
                begin
                    // comment: skip the rest of the line, escape flag untouched
                    comment_skip_next = 1'b1;
                end
                else
                begin
                    escape_pending_next = 1'b0;
                    if (!escape_pending_reg && c == hlt_pkg::CHAR_QUOTE)
                    begin
                        if (!in_quote_reg)
                        begin
                            if (depth_zero && token_nonempty_reg)
                                res = hlt_pkg::push_result(res, hlt_pkg::KIND_END,
                                                           hlt_pkg::CHAR_NONE);
                            res = hlt_pkg::push_result(res, hlt_pkg::KIND_APPEND, c);
                            token_nonempty_next = 1'b1;
                            in_quote_next       = 1'b1;
                        end
                        else
                        begin
                            res = hlt_pkg::push_result(res, hlt_pkg::KIND_APPEND, c);
                            token_nonempty_next = 1'b1;
                            if (depth_zero)
                            begin
                                res = hlt_pkg::push_result(res, hlt_pkg::KIND_END,
                                                           hlt_pkg::CHAR_NONE);
                                token_nonempty_next = 1'b0;
                            end
                            in_quote_next = 1'b0;
                        end
                    end
                    else if (!in_quote_reg && depth_zero
                             && (c == hlt_pkg::CHAR_SPACE || c == hlt_pkg::CHAR_TAB))
                    begin
                        if (token_nonempty_reg)
                            res = hlt_pkg::push_result(res, hlt_pkg::KIND_END,
                                                       hlt_pkg::CHAR_NONE);
                        token_nonempty_next = 1'b0;
                    end
                    else if (!in_quote_reg && c == hlt_pkg::CHAR_LPAREN)
                    begin
                        paren_depth_next = depth_up;
                        if (depth_up == hlt_pkg::depth_t'(1) && token_nonempty_reg)
                            res = hlt_pkg::push_result(res, hlt_pkg::KIND_END,
                                                       hlt_pkg::CHAR_NONE);
                        res = hlt_pkg::push_result(res, hlt_pkg::KIND_APPEND, c);
                        token_nonempty_next = 1'b1;
                    end
                    else if (!in_quote_reg && c == hlt_pkg::CHAR_RPAREN)
                    begin
                        if (depth_one)
                        begin
                            paren_depth_next = '0;
                            res = hlt_pkg::push_result(res, hlt_pkg::KIND_APPEND, c);
                            res = hlt_pkg::push_result(res, hlt_pkg::KIND_END,
                                                       hlt_pkg::CHAR_NONE);
                            token_nonempty_next = 1'b0;
                        end
                        else if (depth_zero)
                        begin
                            // unmatched close: end the token, drop the byte
                            if (token_nonempty_reg)
                                res = hlt_pkg::push_result(res, hlt_pkg::KIND_END,
                                                           hlt_pkg::CHAR_NONE);
                            token_nonempty_next = 1'b0;
                        end
                        else
                        begin
                            paren_depth_next = paren_depth_reg - hlt_pkg::depth_t'(1);
                            res = hlt_pkg::push_result(res, hlt_pkg::KIND_APPEND, c);
                            token_nonempty_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (escape_pending_reg && !depth_zero)
                        begin
                            res = hlt_pkg::push_result(res, hlt_pkg::KIND_APPEND,
                                                       hlt_pkg::CHAR_BSLASH);
                            res = hlt_pkg::push_result(res, hlt_pkg::KIND_APPEND, c);
                        end
                        else if (escape_pending_reg && c == hlt_pkg::CHAR_LOWER_N)
                            res = hlt_pkg::push_result(res, hlt_pkg::KIND_APPEND,
                                                       hlt_pkg::CHAR_NEWLINE);
                        else
                            res = hlt_pkg::push_result(res, hlt_pkg::KIND_APPEND, c);
                        token_nonempty_next = 1'b1;
                    end
                end
            end
        end
        else
        begin
            if (item.line_is_last || (!in_quote_reg && depth_zero))
            begin
                if (token_nonempty_reg)
                    res = hlt_pkg::push_result(res, hlt_pkg::KIND_END, hlt_pkg::CHAR_NONE);
                res = hlt_pkg::push_result(res, hlt_pkg::KIND_DONE, hlt_pkg::CHAR_NONE);
                in_quote_next       = 1'b0;
                escape_pending_next = 1'b0;
                paren_depth_next    = '0;
                token_nonempty_next = 1'b0;
                comment_skip_next   = 1'b0;
            end
            else
            begin
                if (in_quote_reg)
                begin
                    res = hlt_pkg::push_result(res, hlt_pkg::KIND_APPEND,
                                               hlt_pkg::CHAR_NEWLINE);
                    token_nonempty_next = 1'b1;
                end
                res = hlt_pkg::push_result(res, hlt_pkg::KIND_MORE, hlt_pkg::CHAR_NONE);
                comment_skip_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quote_reg       <= 1'b0;
            escape_pending_reg <= 1'b0;
            paren_depth_reg    <= '0;
            token_nonempty_reg <= 1'b0;
            comment_skip_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            in_quote_reg       <= in_quote_next;
            escape_pending_reg <= escape_pending_next;
            paren_depth_reg    <= paren_depth_next;
            token_nonempty_reg <= token_nonempty_next;
            comment_skip_reg   <= comment_skip_next;
        end
    end

endmodule

@@ src/hlt_resbuf.sv @@
module hlt_resbuf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load_en,
    input  hlt_pkg::res_pair_t load_pair,
    output logic               can_load,
    output logic               head_valid,
    input  logic               head_ready,
    output hlt_pkg::result_t   head
);

    hlt_pkg::result_t r0_reg, r0_next;
    hlt_pkg::result_t r1_reg, r1_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             pop;

    assign head_valid = (cnt_reg != 2'd0);
    assign head       = r0_reg;
    assign pop        = head_valid && head_ready;
    assign can_load   = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && head_ready);

    always_comb
    begin
        r0_next  = r0_reg;
        r1_next  = r1_reg;
        cnt_next = cnt_reg;
        if (load_en)
        begin
            r0_next  = load_pair.r0;
            r1_next  = load_pair.r1;
            cnt_next = load_pair.cnt;
        end
        else if (pop)
        begin
            // second result moves to the head
            r0_next  = r1_reg;
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        r0_reg <= r0_next;
        r1_reg <= r1_next;
    end

endmodule

@@ src/header_line_tokenizer.sv @@
// channel       | role   | one transfer carries
// --------------+--------+----------------------------------------------
// char_stream   | sink   | action, char_code, trimmed, line_is_last
// token_stream  | source | kind, out_char, last
//
// one input transfer per cycle while the result buffer can load; a byte or end of line
// producing two results holds the input while the result buffer still holds both
// an input transfer goes through the input register, then the result buffer
// rst_n clears the tokenizer flags, the depth counter and both valid marks
// a stalled token_stream fills the result buffer, then the input register,
// then char_stream.ready falls
module header_line_tokenizer (
    input logic         clk,
    input logic         rst_n,
    hlt_char_if.sink    char_stream,
    hlt_token_if.source token_stream
);

    // input register
    logic               in_full_reg;
    hlt_pkg::item_t     item_reg;
    hlt_pkg::item_t     item_in;

    // step results and handshakes between the parts
    hlt_pkg::res_pair_t step_res;
    hlt_pkg::result_t   head;
    logic               can_load;
    logic               advance;
    logic               in_xfer;

    assign item_in.action       = char_stream.action;
    assign item_in.char_code    = char_stream.char_code;
    assign item_in.trimmed      = char_stream.trimmed;
    assign item_in.line_is_last = char_stream.line_is_last;

    // the held item moves on when the result buffer can take its results
    assign advance           = in_full_reg && can_load;
    assign char_stream.ready = !in_full_reg || can_load;
    assign in_xfer           = char_stream.valid && char_stream.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (in_xfer)
            in_full_reg <= 1'b1;
        else if (advance)
            in_full_reg <= 1'b0;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            item_reg <= item_in;
    end

    // tokenizer state and the per-byte decision
    hlt_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (item_reg),
        .res     (step_res)
    );

    // holds up to two results and hands them out one per transfer
    hlt_resbuf u_resbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_en    (advance),
        .load_pair  (step_res),
        .can_load   (can_load),
        .head_valid (token_stream.valid),
        .head_ready (token_stream.ready),
        .head       (head)
    );

    assign token_stream.kind     = head.kind;
    assign token_stream.out_char = head.out_char;
    assign token_stream.last     = head.last;

endmodule

@@ src/hlt_checker.sv @@
`include "assert_macros.svh"

module hlt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] out_kind,
    input logic [7:0] out_char,
    input logic       out_last
);

    logic        non_append;
    logic        status_kind;
    logic        out_xfer;
    logic        out_stall;
    logic        in_idle;
    logic [10:0] out_bundle;

    assign non_append  = out_valid && out_kind != hlt_pkg::KIND_APPEND;
    assign status_kind = out_kind == hlt_pkg::KIND_DONE || out_kind == hlt_pkg::KIND_MORE;
    assign out_xfer    = out_valid && out_ready;
    assign out_stall   = out_valid && !out_ready;
    assign in_idle     = !in_valid && !out_valid;
    assign out_bundle  = {out_kind, out_char, out_last};

    // only appended characters carry a byte
    `HLT_ASSERT_IMP(a_char_zero, non_append, out_char == 8'h00, "non-append result with a byte")

    // line status always closes the results of its item
    `HLT_ASSERT_IMP(a_status_last, out_valid && status_kind, out_last, "status without last mark")

    // the second result of a pair follows at once
    `HLT_ASSERT_NXT(a_pair_follows, out_xfer && !out_last, out_valid, "second result not ready")

    // a stalled result holds
    `HLT_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(out_bundle), "stalled result moved")

    // an idle input side is always taken
    `HLT_ASSERT_NXT(a_idle_ready, in_idle, in_ready, "input refused while idle")

endmodule

bind header_line_tokenizer hlt_checker u_hlt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (char_stream.valid),
    .in_ready  (char_stream.ready),
    .out_valid (token_stream.valid),
    .out_ready (token_stream.ready),
    .out_kind  (token_stream.kind),
    .out_char  (token_stream.out_char),
    .out_last  (token_stream.last)
);
